@@ hdl/dbt_pkg.sv @@
`default_nettype none

package dbt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // field widths
  localparam int KEY_W = 64;
  localparam int DOM_W = 8;
  localparam int OP_W = 3;
  localparam int STAT_W = 3;
  localparam int TCNT_W = 5;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_DOMAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVALID_ID_CODE = 2'd2;

  // opcodes
  localparam logic [OP_W-1:0] OP_BIND = 3'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd1;
  localparam logic [OP_W-1:0] OP_TRANSFER = 3'd2;
  localparam logic [OP_W-1:0] OP_GET = 3'd3;
  localparam logic [OP_W-1:0] OP_UNBIND = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK = 3'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ALREADY = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FULL = 3'd3;
  localparam logic [STAT_W-1:0] STAT_VIOLATION = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_BOUND = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [KEY_W-1:0] entity_key;
    logic [DOM_W-1:0] target_domain;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DOM_W-1:0]  domain_out;
    logic [TCNT_W-1:0] tracked_count;
  } result_t;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [DOM_W-1:0] domain;
  } entry_t;

  // outcome of one table scan
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [DOM_W-1:0] hit_dom;
    logic             free_ok;
    logic [IDX_W-1:0] free_idx;
  } scan_res_t;

endpackage

`default_nettype wire

@@ hdl/domain_binding_table_core.sv @@
`default_nettype none

// domain binding table: maps 64-bit entity keys to 8-bit domain numbers in a
// table of dbt_pkg::TABLE_ENTRIES slots and checks ownership against the
// current_domain register. a command transaction is taken when start is high
// and busy is low; busy then stays high while one comparator walks the table
// ram one entry per cycle, after which the table and the used count are
// updated and the result is shown on result_o for exactly one cycle with
// done_o high. no new command is taken until the single ram read port and
// key comparator have visited every entry. the receiver cannot stall: a
// result must be taken in the cycle it is shown. a new command may be
// accepted in that same cycle. reset frees every slot; the current_domain,
// wildcard_code and invalid_id_code registers sit on the apb port at byte
// addresses 0, 8 and 16; the user must see that they are only written while
// idle, as the block itself does not enforce it.
module domain_binding_table_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // command channel
  input  wire logic                           start,
  output      logic                           busy,
  input  wire dbt_pkg::cmd_t                  cmd_i,
  // result channel
  output      logic                           done_o,
  output      dbt_pkg::result_t               result_o,
  // configuration port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dbt_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [dbt_pkg::DATA_W-1:0]     pwdata,
  output      logic [dbt_pkg::DATA_W-1:0]     prdata,
  output      logic                           pready
);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  localparam logic [dbt_pkg::IDX_W-1:0] LAST_IDX =
    dbt_pkg::IDX_W'(dbt_pkg::TABLE_ENTRIES - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [dbt_pkg::DOM_W-1:0]     cur_dom_q;
  logic [dbt_pkg::DOM_W-1:0]     wild_q;
  logic [dbt_pkg::KEY_W-1:0]     inv_id_q;
  logic [dbt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic                          cfg_we;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[dbt_pkg::ADDR_W-1:3];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_dom_q <= 8'hff;
      wild_q    <= 8'hff;
      inv_id_q  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dbt_pkg::CFG_CURRENT_DOMAIN:  cur_dom_q <= pwdata[dbt_pkg::DOM_W-1:0];
        dbt_pkg::CFG_WILDCARD_CODE:   wild_q    <= pwdata[dbt_pkg::DOM_W-1:0];
        dbt_pkg::CFG_INVALID_ID_CODE: inv_id_q  <= pwdata[dbt_pkg::KEY_W-1:0];
        default: ; // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dbt_pkg::CFG_CURRENT_DOMAIN:
        prdata = dbt_pkg::DATA_W'(cur_dom_q);
      dbt_pkg::CFG_WILDCARD_CODE:
        prdata = dbt_pkg::DATA_W'(wild_q);
      dbt_pkg::CFG_INVALID_ID_CODE:
        prdata = dbt_pkg::DATA_W'(inv_id_q);
      default:
        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // command capture and sequencer
  // ---------------------------------------------------------------------------
  logic [1:0]                 state_q, state_d;
  logic [dbt_pkg::IDX_W-1:0]  cnt_q, cnt_d;
  dbt_pkg::cmd_t              cmd_q;
  logic                       inv_key_q;  // key equals the invalid id
  logic                       accept;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        // one ram read issued per cycle
        if (cnt_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: state_d = S_RESP;  // last read data compared here
      S_RESP:  state_d = S_IDLE;  // table update and result
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // payload of the command held for the whole transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      inv_key_q <= (cmd_i.entity_key == inv_id_q);
    end
  end

  // ---------------------------------------------------------------------------
  // table storage: key and domain in ram, used bits in flops
  // ---------------------------------------------------------------------------
  logic [dbt_pkg::TABLE_ENTRIES-1:0] used_q, used_d;
  logic [dbt_pkg::CNT_W-1:0]         total_q, total_d;
  logic                              ram_we;
  logic [dbt_pkg::IDX_W-1:0]         ram_waddr;
  dbt_pkg::entry_t                   ram_wdata;
  dbt_pkg::entry_t                   ram_rdata;
  dbt_pkg::scan_res_t                scan;

  dbt_ram #(
    .WIDTH ($bits(dbt_pkg::entry_t)),
    .DEPTH (dbt_pkg::TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // key comparator and first-match / first-free tracking
  dbt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (accept),
    .iss_vld_i  (state_q == S_SCAN),
    .iss_idx_i  (cnt_q),
    .iss_used_i (used_q[cnt_q]),
    .key_i      (cmd_q.entity_key),
    .rdata_i    (ram_rdata),
    .res_o      (scan)
  );

  // ---------------------------------------------------------------------------
  // decision and write-back, evaluated in the response state
  // ---------------------------------------------------------------------------
  logic                        access_ok;
  logic [dbt_pkg::STAT_W-1:0]  status;
  logic [dbt_pkg::DOM_W-1:0]   dom_out;

  // wildcard on either side always passes
  assign access_ok = (scan.hit_dom == wild_q) || (cur_dom_q == wild_q) ||
                     (cur_dom_q == scan.hit_dom);

  always_comb begin
    status    = dbt_pkg::STAT_OK;
    dom_out   = '0;
    used_d    = used_q;
    total_d   = total_q;
    ram_we    = 1'b0;
    ram_waddr = scan.hit_idx;
    ram_wdata = '{key: cmd_q.entity_key, domain: cmd_q.target_domain};
    if (state_q == S_RESP) begin
      if (cmd_q.opcode == dbt_pkg::OP_UNBIND) begin
        // unbind skips the invalid key test and always answers ok
        if (scan.hit) begin
          used_d[scan.hit_idx] = 1'b0;
          if (total_q != '0) begin
            total_d = total_q - 1'b1;
          end
        end
      end else if (cmd_q.opcode > dbt_pkg::OP_UNBIND || inv_key_q) begin
        status = dbt_pkg::STAT_INVALID;
      end else begin
        case (cmd_q.opcode)
          dbt_pkg::OP_BIND: begin
            if (scan.hit) begin
              // rebind only to the same domain or over a wildcard binding
              if (scan.hit_dom != cmd_q.target_domain && scan.hit_dom != wild_q) begin
                status = dbt_pkg::STAT_ALREADY;
              end else begin
                ram_we = 1'b1;
              end
            end else if (scan.free_ok) begin
              ram_we                = 1'b1;
              ram_waddr             = scan.free_idx;
              used_d[scan.free_idx] = 1'b1;
              total_d               = total_q + 1'b1;
            end else begin
              status = dbt_pkg::STAT_FULL;
            end
          end
          dbt_pkg::OP_CHECK: begin
            // an untracked key passes
            if (scan.hit && !access_ok) begin
              status = dbt_pkg::STAT_VIOLATION;
            end
          end
          dbt_pkg::OP_TRANSFER: begin
            if (!scan.hit) begin
              status = dbt_pkg::STAT_NOT_BOUND;
            end else if (!access_ok) begin
              status = dbt_pkg::STAT_VIOLATION;
            end else begin
              ram_we = 1'b1;
            end
          end
          default: begin
            // get domain
            if (!scan.hit) begin
              status = dbt_pkg::STAT_NOT_BOUND;
            end else begin
              dom_out = scan.hit_dom;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      total_q <= '0;
    end else begin
      used_q  <= used_d;
      total_q <= total_d;
    end
  end

  // ---------------------------------------------------------------------------
  // result register: one-cycle strobe
  // ---------------------------------------------------------------------------
  logic             done_q;
  dbt_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_RESP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RESP) begin
      result_q.status        <= status;
      result_q.domain_out    <= dom_out;
      result_q.tracked_count <= dbt_pkg::TCNT_W'(total_d);
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_count_matches_used: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    total_q == dbt_pkg::CNT_W'($countones(used_q))
  ) else $error("used count disagrees with used bits");

  a_accept_starts_scan: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN && cnt_q == '0)
  ) else $error("accepted command did not start a scan at entry zero");

  a_done_after_resp: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_RESP)
  ) else $error("result strobe without a response state");

  a_done_when_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy
  ) else $error("result shown while a scan is running");

  a_write_only_in_resp: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_RESP)
  ) else $error("table write outside the response state");

endmodule

`default_nettype wire

@@ hdl/dbt_ram.sv @@
`default_nettype none

module dbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [WIDTH-1:0]          wdata_i,
  input  wire logic [AW-1:0]             raddr_i,
  output      logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/dbt_scan.sv @@
`default_nettype none

module dbt_scan (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clr_i,
  input  wire logic                         iss_vld_i,
  input  wire logic [dbt_pkg::IDX_W-1:0]    iss_idx_i,
  input  wire logic                         iss_used_i,
  input  wire logic [dbt_pkg::KEY_W-1:0]    key_i,
  input  wire dbt_pkg::entry_t              rdata_i,
  output      dbt_pkg::scan_res_t           res_o
);

  logic                      iss_vld_q;
  logic [dbt_pkg::IDX_W-1:0] iss_idx_q;
  logic                      iss_used_q;
  dbt_pkg::scan_res_t        res_q, res_d;
  logic                      key_eq;

  // ram read data arrives in the cycle after its index is issued
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q  <= 1'b0;
      iss_idx_q  <= '0;
      iss_used_q <= 1'b0;
    end else begin
      iss_vld_q  <= iss_vld_i;
      iss_idx_q  <= iss_idx_i;
      iss_used_q <= iss_used_i;
    end
  end

  // the shared 64-bit key comparator
  assign key_eq = (rdata_i.key == key_i);

  always_comb begin
    res_d = res_q;
    if (clr_i) begin
      res_d = '0;
    end else if (iss_vld_q) begin
      // lowest matching used slot wins
      if (iss_used_q && key_eq && !res_q.hit) begin
        res_d.hit     = 1'b1;
        res_d.hit_idx = iss_idx_q;
        res_d.hit_dom = rdata_i.domain;
      end
      // lowest free slot
      if (!iss_used_q && !res_q.free_ok) begin
        res_d.free_ok  = 1'b1;
        res_d.free_idx = iss_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // the time one transaction occupies the block, from accept to the next accept
  localparam int ITEM_CYCLES = dbt_pkg::TABLE_ENTRIES + 3;
  localparam int SETTLE_CYCLES = 2 * ITEM_CYCLES;
  // longest quiet stretch of a correct run is one item plus the longest sender gap
  localparam int WATCHDOG_LIMIT = 20 * ITEM_CYCLES;
  localparam int KEY_POOL_SIZE = 24;
  localparam int MAX_GAP = 25;
  // the register index past the last real register, writes there are dropped
  localparam logic [dbt_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // ownership predictor plus the queue of results still owed by the block
  class ownership_scoreboard;
    logic [dbt_pkg::KEY_W-1:0] slot_keys[dbt_pkg::TABLE_ENTRIES];
    logic [dbt_pkg::DOM_W-1:0] slot_doms[dbt_pkg::TABLE_ENTRIES];
    bit                        slot_taken[dbt_pkg::TABLE_ENTRIES];
    int unsigned               bound_total;
    logic [dbt_pkg::DOM_W-1:0] cur_domain;
    logic [dbt_pkg::DOM_W-1:0] wild_domain;
    logic [dbt_pkg::KEY_W-1:0] bad_key;
    dbt_pkg::result_t          pending_results[$];
    int unsigned               errors;

    function new();
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      bound_total = 0;
      cur_domain = 8'hFF;
      wild_domain = 8'hFF;
      bad_key = '0;
      errors = 0;
    endfunction

    function int find_key(logic [dbt_pkg::KEY_W-1:0] key);
      for (int i = 0; i < dbt_pkg::TABLE_ENTRIES; i++) begin
        if (slot_taken[i] && slot_keys[i] == key) return i;
      end
      return -1;
    endfunction

    function bit may_access(logic [dbt_pkg::DOM_W-1:0] dom);
      return dom == wild_domain || cur_domain == wild_domain || cur_domain == dom;
    endfunction

    function void write_reg(logic [dbt_pkg::CFG_IDX_W-1:0] idx,
                            logic [dbt_pkg::DATA_W-1:0] value);
      case (idx)
        dbt_pkg::CFG_CURRENT_DOMAIN:  cur_domain = value[dbt_pkg::DOM_W-1:0];
        dbt_pkg::CFG_WILDCARD_CODE:   wild_domain = value[dbt_pkg::DOM_W-1:0];
        dbt_pkg::CFG_INVALID_ID_CODE: bad_key = value[dbt_pkg::KEY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [dbt_pkg::DATA_W-1:0] reg_value(logic [dbt_pkg::CFG_IDX_W-1:0] idx);
      case (idx)
        dbt_pkg::CFG_CURRENT_DOMAIN: return dbt_pkg::DATA_W'(cur_domain);
        dbt_pkg::CFG_WILDCARD_CODE:  return dbt_pkg::DATA_W'(wild_domain);
        default:                     return dbt_pkg::DATA_W'(bad_key);
      endcase
    endfunction

    // advance the predicted table by one accepted command
    function void predict_ownership(dbt_pkg::cmd_t c);
      dbt_pkg::result_t r;
      int               s;
      int               f;
      r = '0;
      r.status = dbt_pkg::STAT_OK;
      if (c.opcode == dbt_pkg::OP_UNBIND) begin
        // unbind never looks at the invalid key and always answers ok
        s = find_key(c.entity_key);
        if (s >= 0) begin
          slot_taken[s] = 1'b0;
          if (bound_total > 0) bound_total--;
        end
      end else if (c.opcode > dbt_pkg::OP_UNBIND) begin
        r.status = dbt_pkg::STAT_INVALID;
      end else if (c.entity_key == bad_key) begin
        r.status = dbt_pkg::STAT_INVALID;
      end else begin
        s = find_key(c.entity_key);
        case (c.opcode)
          dbt_pkg::OP_BIND: begin
            if (s >= 0) begin
              // rebind only onto the same domain or over a wildcard owner
              if (slot_doms[s] != c.target_domain && slot_doms[s] != wild_domain)
                r.status = dbt_pkg::STAT_ALREADY;
              else
                slot_doms[s] = c.target_domain;
            end else begin
              f = -1;
              for (int i = dbt_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
                if (!slot_taken[i]) f = i;
              end
              if (f < 0) begin
                r.status = dbt_pkg::STAT_FULL;
              end else begin
                slot_keys[f] = c.entity_key;
                slot_doms[f] = c.target_domain;
                slot_taken[f] = 1'b1;
                bound_total++;
              end
            end
          end
          dbt_pkg::OP_CHECK: begin
            // an untracked key passes
            if (s >= 0 && !may_access(slot_doms[s])) r.status = dbt_pkg::STAT_VIOLATION;
          end
          dbt_pkg::OP_TRANSFER: begin
            if (s < 0) r.status = dbt_pkg::STAT_NOT_BOUND;
            else if (!may_access(slot_doms[s])) r.status = dbt_pkg::STAT_VIOLATION;
            else slot_doms[s] = c.target_domain;
          end
          default: begin
            if (s < 0) r.status = dbt_pkg::STAT_NOT_BOUND;
            else r.domain_out = slot_doms[s];
          end
        endcase
      end
      r.tracked_count = dbt_pkg::TCNT_W'(bound_total);
      pending_results.push_back(r);
    endfunction

    function void check_result(dbt_pkg::result_t got);
      dbt_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending: status %0d domain %h count %0d",
                 $time, got.status, got.domain_out, got.tracked_count);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.domain_out !== want.domain_out) begin
        $display("%0t: domain_out mismatch, expected %h actual %h",
                 $time, want.domain_out, got.domain_out);
        errors++;
      end
      if (got.tracked_count !== want.tracked_count) begin
        $display("%0t: tracked_count mismatch, expected %0d actual %0d",
                 $time, want.tracked_count, got.tracked_count);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  dbt_pkg::cmd_t              cmd_i = '0;
  logic                       done_o;
  dbt_pkg::result_t           result_o;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [dbt_pkg::ADDR_W-1:0] paddr = '0;
  logic [dbt_pkg::DATA_W-1:0] pwdata = '0;
  logic [dbt_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  ownership_scoreboard sb;
  int                  quiet_cycles;

  // stimulus pools: keys repeat so bindings get hit again, domains cluster
  // around the register values so every ownership outcome shows up
  logic [dbt_pkg::KEY_W-1:0] key_pool[KEY_POOL_SIZE];
  logic [dbt_pkg::DOM_W-1:0] dom_pool[3];

  domain_binding_table_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // monitor: everything is sampled at the rising edge, before the block's
  // own updates land, so the order of processes in a step does not matter
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      // a result leaving and a new command entering on one edge is legal
      if (done_o) sb.check_result(result_o);
      if (start && !busy) sb.predict_ownership(cmd_i);
      if (psel && penable && pwrite && pready)
        sb.write_reg(paddr[dbt_pkg::ADDR_W-1:3], pwdata);
      if (done_o || (start && !busy) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      // watchdog: nothing moved for far longer than a correct block needs
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired after %0d quiet cycles", $time, quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // present one command and hold it until the block takes the transaction;
  // start stays high on return so back-to-back commands never drop it
  task automatic issue(dbt_pkg::cmd_t c);
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
  endtask

  // sender gap; the command bus carries junk meanwhile to show it is ignored
  task automatic pause(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
      cmd_i <= '{opcode: dbt_pkg::OP_W'($urandom),
                 entity_key: {$urandom, $urandom},
                 target_domain: dbt_pkg::DOM_W'($urandom)};
    end
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain();
    pause(1);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    pause(2);
  endtask

  task automatic apb_access(bit wr, logic [dbt_pkg::ADDR_W-1:0] addr,
                            logic [dbt_pkg::DATA_W-1:0] wdata,
                            output logic [dbt_pkg::DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // register write followed by a read-back of the same register, unless it is unmapped
  task automatic cfg_write(logic [dbt_pkg::CFG_IDX_W-1:0] idx,
                           logic [dbt_pkg::DATA_W-1:0] value);
    logic [dbt_pkg::ADDR_W-1:0] addr;
    logic [dbt_pkg::DATA_W-1:0] rd;
    addr = {idx, 3'b000};
    apb_access(1'b1, addr, value, rd);
    if (idx != CFG_UNMAPPED) begin
      apb_access(1'b0, addr, '0, rd);
      if (rd !== sb.reg_value(idx)) begin
        $display("%0t: read-back of register %0d, expected %h actual %h",
                 $time, idx, sb.reg_value(idx), rd);
        sb.errors++;
      end
    end
  endtask

  // new register setting; upper bits of the narrow registers carry junk
  task automatic cfg_phase(logic [dbt_pkg::DOM_W-1:0] cur, logic [dbt_pkg::DOM_W-1:0] wild,
                           logic [dbt_pkg::KEY_W-1:0] bad);
    drain();
    cfg_write(dbt_pkg::CFG_CURRENT_DOMAIN, {$urandom, 24'($urandom), cur});
    cfg_write(dbt_pkg::CFG_WILDCARD_CODE, {$urandom, 24'($urandom), wild});
    cfg_write(dbt_pkg::CFG_INVALID_ID_CODE, dbt_pkg::DATA_W'(bad));
  endtask

  task automatic run_op(logic [dbt_pkg::OP_W-1:0] op, logic [dbt_pkg::KEY_W-1:0] key,
                        logic [dbt_pkg::DOM_W-1:0] dom);
    dbt_pkg::cmd_t c;
    c.opcode = op;
    c.entity_key = key;
    c.target_domain = dom;
    issue(c);
    pause($urandom_range(0, 3));
  endtask

  function automatic logic [dbt_pkg::DOM_W-1:0] pick_domain();
    case ($urandom_range(0, 5)) inside
      0:       return sb.cur_domain;
      1:       return sb.wild_domain;
      [2:4]:   return dom_pool[$urandom_range(0, 2)];
      default: return dbt_pkg::DOM_W'($urandom);
    endcase
  endfunction

  function automatic dbt_pkg::cmd_t make_cmd();
    dbt_pkg::cmd_t c;
    int unsigned   roll;
    roll = $urandom_range(0, 99);
    // bind heavy so the table fills up now and then
    if (roll < 32)      c.opcode = dbt_pkg::OP_BIND;
    else if (roll < 52) c.opcode = dbt_pkg::OP_CHECK;
    else if (roll < 67) c.opcode = dbt_pkg::OP_TRANSFER;
    else if (roll < 80) c.opcode = dbt_pkg::OP_GET;
    else if (roll < 95) c.opcode = dbt_pkg::OP_UNBIND;
    else c.opcode = dbt_pkg::OP_UNBIND + dbt_pkg::OP_W'($urandom_range(1, 3));
    roll = $urandom_range(0, 99);
    if (roll < 5)       c.entity_key = sb.bad_key;
    else if (roll < 10) c.entity_key = {$urandom, $urandom};
    else                c.entity_key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    c.target_domain = pick_domain();
    return c;
  endfunction

  // random traffic in bursts, with one full drain half way through
  task automatic run_random(int count);
    int sent;
    int burst;
    for (int i = 0; i < 8; i++)
      key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = {$urandom, $urandom};
    foreach (dom_pool[i]) dom_pool[i] = dbt_pkg::DOM_W'($urandom);
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      for (int i = 0; i < burst && sent < count; i++) begin
        issue(make_cmd());
        sent++;
        if (sent == count / 2) drain();
      end
      if ($urandom_range(0, 3) == 0) pause(0);
      else pause($urandom_range(1, MAX_GAP));
    end
  endtask

  localparam logic [dbt_pkg::KEY_W-1:0] KEY_ONES = '1;
  localparam logic [dbt_pkg::KEY_W-1:0] KEY_ONE = 64'h1;
  localparam logic [dbt_pkg::KEY_W-1:0] KEY_MIX = 64'h0123_4567_89AB_CDEF;

  initial begin
    sb = new();
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = KEY_ONES;
    key_pool[1] = KEY_ONE;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = KEY_MIX;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    pause(2);

    // directed part under reset registers: key zero is the invalid id
    run_op(dbt_pkg::OP_BIND, '0, 8'h01);
    run_op(dbt_pkg::OP_CHECK, '0, 8'h00);
    run_op(dbt_pkg::OP_TRANSFER, '0, 8'h02);
    run_op(dbt_pkg::OP_GET, '0, 8'h00);
    run_op(dbt_pkg::OP_UNBIND, '0, 8'h00);
    run_op(dbt_pkg::OP_UNBIND + dbt_pkg::OP_W'(1), KEY_MIX, 8'hFF);
    run_op(dbt_pkg::OP_UNBIND + dbt_pkg::OP_W'(2), KEY_MIX, 8'h00);
    run_op(dbt_pkg::OP_UNBIND + dbt_pkg::OP_W'(3), KEY_MIX, 8'hA5);
    // untracked key
    run_op(dbt_pkg::OP_CHECK, KEY_MIX, 8'h00);
    run_op(dbt_pkg::OP_TRANSFER, KEY_MIX, 8'h33);
    run_op(dbt_pkg::OP_GET, KEY_MIX, 8'h00);
    run_op(dbt_pkg::OP_UNBIND, KEY_MIX, 8'h00);
    // same-domain rebind, refused rebind, rebind over a wildcard owner
    run_op(dbt_pkg::OP_BIND, KEY_ONES, 8'h00);
    run_op(dbt_pkg::OP_BIND, KEY_ONES, 8'h00);
    run_op(dbt_pkg::OP_BIND, KEY_ONES, 8'h5A);
    run_op(dbt_pkg::OP_BIND, KEY_ONE, 8'hFF);
    run_op(dbt_pkg::OP_BIND, KEY_ONE, 8'h12);
    // caller no longer the wildcard: ownership violations
    cfg_phase(8'h5A, 8'hFF, '0);
    run_op(dbt_pkg::OP_CHECK, KEY_ONES, 8'h00);
    run_op(dbt_pkg::OP_TRANSFER, KEY_ONES, 8'h5A);
    run_op(dbt_pkg::OP_GET, KEY_ONES, 8'h00);
    run_op(dbt_pkg::OP_TRANSFER, KEY_ONE, 8'h5A);
    run_op(dbt_pkg::OP_BIND, KEY_MIX, 8'hFF);
    run_op(dbt_pkg::OP_CHECK, KEY_MIX, 8'h00);
    run_op(dbt_pkg::OP_UNBIND, KEY_ONES, 8'h00);
    run_op(dbt_pkg::OP_UNBIND, KEY_ONE, 8'h00);

    // random phases over a spread of register settings, table kept between them
    cfg_phase(8'h03, 8'hFF, '0);
    run_random(175);
    cfg_phase(8'h00, 8'h00, '0);
    run_random(175);
    cfg_phase(8'hFF, 8'h00, KEY_ONES);
    cfg_write(CFG_UNMAPPED, {$urandom, $urandom});
    run_random(175);
    cfg_phase(dbt_pkg::DOM_W'($urandom), dbt_pkg::DOM_W'($urandom),
              key_pool[$urandom_range(4, KEY_POOL_SIZE - 1)]);
    run_random(175);
    cfg_phase(8'h80, 8'hFF, {$urandom, $urandom});
    run_random(175);
    cfg_phase(8'h00, 8'hFF, KEY_ONE);
    run_random(150);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
